// ===== rtl/psa_pkg.sv =====
// Package for the priority scheduler with aging: widths, op codes, beat structs
// and the control word passed down the row of task cells. No dependencies.
package psa_pkg;

  localparam int MaxTasks    = 16;
  localparam int Levels      = 16;
  localparam int AgingPeriod = 3;
  localparam int IdW  = 5;
  localparam int LvW  = 4;
  localparam int OrdW = 5;
  localparam int TcW  = 2;
  localparam int IdxW = 4;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FINISH = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]     op;
    logic [IdW-1:0] task_id;
    logic [LvW-1:0] static_level;
    logic [LvW-1:0] dynamic_level;
    logic           is_ready;
  } in_beat_t;

  typedef struct packed {
    logic           running_valid;
    logic [IdW-1:0] running_id;
    logic [1:0]     status;
    logic           preempted;
    logic           aged;
  } out_beat_t;

  // Cell command: every cell sees the same command in a cycle.
  typedef enum logic [2:0] {
    CC_NONE    = 3'd0,
    CC_ENQ     = 3'd1,  // enqueue target at tail position cnt (also writes levels)
    CC_DEQ     = 3'd2,  // dequeue target
    CC_SELECT  = 3'd3,  // target becomes running: set executed, dequeue
    CC_AGE     = 3'd4,  // age target, drop from its queue
    CC_REQUEUE = 3'd5   // re-enqueue target with its own stored levels
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t       cmd;
    logic [IdxW-1:0] idx;
    logic [LvW-1:0]  base;
    logic [LvW-1:0]  cur;
    logic [LvW-1:0]  lv;      // queue level of the target for deq
    logic [OrdW-1:0] ord;     // order of the target for deq
    logic [OrdW-1:0] cnt;     // tail position for enq
  } cell_ctl_t;

  // Cell status word reported back to the controller.
  typedef struct packed {
    logic           waiting;
    logic           executed;
    logic [LvW-1:0] base;
    logic [LvW-1:0] cur;
    logic [OrdW-1:0] ord;
  } cell_stat_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ADD_DEQ, S_CNT, S_ENQ, S_ADD_POST, S_PRE_CNT, S_PRE_ENQ,
    S_SEL_SCAN, S_SEL_DO, S_AGE_SCAN, S_AGE_DO, S_RQ_NEXT, S_RQ_CNT, S_RQ_ENQ,
    S_RQ_POST, S_DONE
  } ps_state_t;

  function automatic logic [LvW-1:0] queue_lv(input logic [LvW-1:0] b,
                                              input logic [LvW-1:0] c);
    return (b == '0) ? '0 : c;
  endfunction

endpackage

// ===== rtl/priority_scheduler_with_aging_top.sv =====
// Top level of the priority scheduler with aging: sequencer plus the row of
// task cells. Depends on psa_pkg, psa_ctrl and psa_cell.
//
// One beat in, one beat out. in_stall is high from acceptance until the
// result is loaded into the output register. A remove or a rejected add
// walks no part of the cell row; an add walks the row once to count its
// queue, once more when it preempts, plus a level-by-level head search
// when a task is selected, and an aging tick walks the row once per level
// and position it finds, then counts and searches once per requeued task.
// The row is walked one slot per cycle.
module priority_scheduler_with_aging_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psa_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psa_pkg::out_beat_t out_data
);
  import psa_pkg::*;

  cell_ctl_t  ctl;
  cell_stat_t stat [MaxTasks];

  psa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .ctl, .stat
  );

  // Build the row of task cells.
  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    psa_cell u_cell (
      .clk, .rst_n, .my_idx(IdxW'(g)), .ctl, .stat(stat[g])
    );
  end

endmodule

// ===== rtl/psa_cell.sv =====
// One task slot of the scheduler row: waiting flag, levels, FCFS order, executed flag.
// Depends on psa_pkg.
module psa_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         my_idx,
  input  psa_pkg::cell_ctl_t ctl,
  output psa_pkg::cell_stat_t stat
);
  import psa_pkg::*;

  logic            waiting_r, waiting_nxt;
  logic            exec_r, exec_nxt;
  logic [LvW-1:0]  base_r, base_nxt;
  logic [LvW-1:0]  cur_r, cur_nxt;
  logic [OrdW-1:0] ord_r, ord_nxt;
  logic            hit;
  logic            same_q;

  assign hit    = (ctl.idx == my_idx);
  assign same_q = waiting_r && (queue_lv(base_r, cur_r) == ctl.lv);

  // Apply the broadcast command to this slot.
  always_comb begin
    waiting_nxt = waiting_r;
    exec_nxt    = exec_r;
    base_nxt    = base_r;
    cur_nxt     = cur_r;
    ord_nxt     = ord_r;
    unique case (ctl.cmd)
      CC_ENQ: begin
        if (hit) begin
          waiting_nxt = 1'b1;
          base_nxt    = ctl.base;
          cur_nxt     = ctl.cur;
          ord_nxt     = ctl.cnt;
        end
      end
      CC_REQUEUE: begin
        if (hit) begin
          waiting_nxt = 1'b1;
          ord_nxt     = ctl.cnt;
        end
      end
      CC_DEQ, CC_SELECT: begin
        if (hit) begin
          waiting_nxt = 1'b0;
          if (ctl.cmd == CC_SELECT) exec_nxt = 1'b1;
        end else if (same_q && ord_r > ctl.ord) begin
          ord_nxt = ord_r - 1'b1;
        end
      end
      CC_AGE: begin
        if (hit) begin
          waiting_nxt = 1'b0;
          if (exec_r) begin
            if (cur_r > base_r) cur_nxt = cur_r - 1'b1;
            else exec_nxt = 1'b0;
          end else if (cur_r < LvW'(Levels - 1)) begin
            cur_nxt = cur_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Hold slot state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      exec_r    <= 1'b0;
    end else begin
      waiting_r <= waiting_nxt;
      exec_r    <= exec_nxt;
    end
    base_r <= base_nxt;
    cur_r  <= cur_nxt;
    ord_r  <= ord_nxt;
  end

  assign stat = '{waiting: waiting_r, executed: exec_r, base: base_r, cur: cur_r,
                  ord: ord_r};

endmodule

// ===== rtl/psa_ctrl.sv =====
// Sequencer of the scheduler: walks the cell row one slot a cycle for counts,
// searches and the aging list, and issues one cell command a cycle. Uses psa_pkg.
module psa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psa_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psa_pkg::out_beat_t   out_data,
  output psa_pkg::cell_ctl_t   ctl,
  input  psa_pkg::cell_stat_t  stat [psa_pkg::MaxTasks]
);
  import psa_pkg::*;

  localparam int CntW = IdxW + 1;

  ps_state_t       state_r, state_nxt;
  in_beat_t        req_r;
  logic [IdxW-1:0] idx_r, idx_nxt;          // target slot
  logic [LvW-1:0]  lv_r, lv_nxt;            // queue level for count / search
  logic [CntW-1:0] cnt_r, cnt_nxt;          // running count
  logic [IdxW-1:0] k_r, k_nxt;              // walk pointer
  logic [IdW-1:0]  run_id_r, run_id_nxt;
  logic [LvW-1:0]  run_lv_r, run_lv_nxt;
  logic [TcW-1:0]  tick_r, tick_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            pre_r, pre_nxt;
  logic            aged_r, aged_nxt;
  logic            enq_rq_r, enq_rq_nxt;    // current enqueue is a requeue
  logic            in_age_r, in_age_nxt;    // select runs inside aging requeue
  logic [IdxW-1:0] list_r [MaxTasks];
  logic [CntW-1:0] nlist_r, nlist_nxt;
  logic [CntW-1:0] j_r, j_nxt;
  logic [IdxW-1:0] list_wr_idx;
  logic            list_we;
  logic [LvW-1:0]  scan_lv_r, scan_lv_nxt;
  logic [OrdW-1:0] scan_pos_r, scan_pos_nxt;
  logic            scan_hit_r, scan_hit_nxt; // any slot at this level in pass
  out_beat_t       out_r;
  logic            out_valid_r, out_load;
  cell_stat_t      sk;
  logic [LvW-1:0]  slv, dlv;
  logic            id_ok;
  logic [IdxW-1:0] id_idx;
  logic            last_k;
  logic            age_hit;
  logic            rm_hit;

  assign sk     = stat[k_r];
  assign slv    = req_r.static_level;
  assign dlv    = req_r.dynamic_level;
  assign id_ok  = (req_r.task_id != '0) && (req_r.task_id <= IdW'(MaxTasks));
  assign id_idx = IdxW'(req_r.task_id - 1'b1);
  assign last_k = (k_r == IdxW'(MaxTasks - 1));
  assign age_hit = sk.waiting && (queue_lv(sk.base, sk.cur) == scan_lv_r) &&
                   (sk.ord == scan_pos_r);
  assign rm_hit = id_ok && stat[id_idx].waiting && (stat[id_idx].cur == dlv);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r;  idx_nxt = idx_r;  lv_nxt = lv_r;
    cnt_nxt = cnt_r;  k_nxt = k_r;  run_id_nxt = run_id_r;  run_lv_nxt = run_lv_r;
    tick_nxt = tick_r;  status_nxt = status_r;  pre_nxt = pre_r;  aged_nxt = aged_r;
    enq_rq_nxt = enq_rq_r;  in_age_nxt = in_age_r;
    nlist_nxt = nlist_r;  j_nxt = j_r;
    scan_lv_nxt = scan_lv_r;  scan_pos_nxt = scan_pos_r;  scan_hit_nxt = scan_hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
        status_nxt = ST_DONE;  pre_nxt = 1'b0;  aged_nxt = 1'b0;
        in_age_nxt = 1'b0;  enq_rq_nxt = 1'b0;
      end
      S_DECODE: begin
        idx_nxt = id_idx;
        k_nxt = '0;  cnt_nxt = '0;
        unique case (op_t'(req_r.op))
          OP_ADD: begin
            if (!id_ok || !req_r.is_ready || run_id_r == req_r.task_id) begin
              status_nxt = ST_REJECT;  state_nxt = S_DONE;
            end else begin
              state_nxt = S_ADD_DEQ;
            end
          end
          OP_REMOVE: begin
            if (!rm_hit) status_nxt = ST_NOTFOUND;
            state_nxt = S_DONE;
          end
          OP_FINISH: begin
            run_id_nxt = '0;  run_lv_nxt = '0;
            lv_nxt = LvW'(Levels - 1);  state_nxt = S_SEL_SCAN;
          end
          default: begin
            if (tick_r + 1'b1 >= TcW'(AgingPeriod)) begin
              tick_nxt = '0;  aged_nxt = 1'b1;  in_age_nxt = 1'b1;
              nlist_nxt = '0;  scan_lv_nxt = LvW'(1);  scan_pos_nxt = '0;
              scan_hit_nxt = 1'b0;
              state_nxt = S_AGE_SCAN;
            end else begin
              tick_nxt = tick_r + 1'b1;  state_nxt = S_DONE;
            end
          end
        endcase
      end
      // Drop an add target from its old place if already waiting.
      S_ADD_DEQ: begin
        lv_nxt = queue_lv(slv, dlv);
        k_nxt = '0;  cnt_nxt = '0;  enq_rq_nxt = 1'b0;
        state_nxt = S_CNT;
      end
      // Count waiting slots at queue level lv, one slot a cycle.
      S_CNT: begin
        if (sk.waiting && queue_lv(sk.base, sk.cur) == lv_r) cnt_nxt = cnt_r + 1'b1;
        k_nxt = k_r + 1'b1;
        if (last_k) state_nxt = S_ENQ;
      end
      S_ENQ: begin
        state_nxt = S_ADD_POST;
      end
      // Selection and preemption rules after an enqueue.
      S_ADD_POST: begin
        lv_nxt = LvW'(Levels - 1);  k_nxt = '0;
        if (stat[idx_r].base == '0) begin
          state_nxt = (run_id_r == '0) ? S_SEL_SCAN : (in_age_r ? S_RQ_NEXT : S_DONE);
        end else if (run_id_r == '0) begin
          state_nxt = S_SEL_SCAN;
        end else if (stat[idx_r].cur > run_lv_r) begin
          pre_nxt = 1'b1;
          idx_nxt = IdxW'(run_id_r - 1'b1);
          lv_nxt  = queue_lv(stat[IdxW'(run_id_r - 1'b1)].base, run_lv_r);
          cnt_nxt = '0;
          state_nxt = S_PRE_CNT;
        end else begin
          state_nxt = in_age_r ? S_RQ_NEXT : S_DONE;
        end
      end
      S_PRE_CNT: begin
        if (sk.waiting && queue_lv(sk.base, sk.cur) == lv_r) cnt_nxt = cnt_r + 1'b1;
        k_nxt = k_r + 1'b1;
        if (last_k) state_nxt = S_PRE_ENQ;
      end
      S_PRE_ENQ: begin
        lv_nxt = LvW'(Levels - 1);  k_nxt = '0;
        state_nxt = S_SEL_SCAN;
      end
      // Find the head of the highest non-empty level, level by level.
      S_SEL_SCAN: begin
        if (sk.waiting && queue_lv(sk.base, sk.cur) == lv_r && sk.ord == '0) begin
          idx_nxt = k_r;  state_nxt = S_SEL_DO;
        end else begin
          k_nxt = k_r + 1'b1;
          if (last_k) begin
            if (lv_r == '0) state_nxt = in_age_r ? S_RQ_NEXT : S_DONE;
            else lv_nxt = lv_r - 1'b1;
          end
        end
      end
      S_SEL_DO: begin
        run_id_nxt = IdW'(idx_r) + 1'b1;
        run_lv_nxt = stat[idx_r].cur;
        state_nxt = in_age_r ? S_RQ_NEXT : S_DONE;
      end
      // Build the aging list: level ascending, then position, then slot.
      S_AGE_SCAN: begin
        if (age_hit) begin
          nlist_nxt = nlist_r + 1'b1;  scan_hit_nxt = 1'b1;
        end
        k_nxt = k_r + 1'b1;
        if (last_k) begin
          // no slot at this position: no later position exists at this level
          if ((!scan_hit_r && !age_hit) || scan_pos_r == OrdW'(MaxTasks - 1)) begin
            scan_pos_nxt = '0;
            if (scan_lv_r == LvW'(Levels - 1)) begin
              j_nxt = '0;  state_nxt = S_AGE_DO;
            end else begin
              scan_lv_nxt = scan_lv_r + 1'b1;
            end
          end else begin
            scan_pos_nxt = scan_pos_r + 1'b1;
          end
          scan_hit_nxt = 1'b0;
        end
      end
      S_AGE_DO: begin
        if (j_r == nlist_r) begin
          j_nxt = '0;  state_nxt = S_RQ_NEXT;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      // Requeue each aged task in list order with normal add rules.
      S_RQ_NEXT: begin
        if (j_r == nlist_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = list_r[IdxW'(j_r)];
          lv_nxt  = queue_lv(stat[list_r[IdxW'(j_r)]].base,
                             stat[list_r[IdxW'(j_r)]].cur);
          j_nxt = j_r + 1'b1;  k_nxt = '0;  cnt_nxt = '0;  enq_rq_nxt = 1'b1;
          state_nxt = S_CNT;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Drive cell commands, aging list writes and the result load.
  always_comb begin
    list_we = 1'b0;  list_wr_idx = k_r;
    out_load = 1'b0;
    ctl = '0;
    ctl.cmd = CC_NONE;
    unique case (state_r)
      S_DECODE: begin
        if (op_t'(req_r.op) == OP_REMOVE && rm_hit) begin
          ctl.cmd = CC_DEQ;  ctl.idx = id_idx;
          ctl.lv  = queue_lv(stat[id_idx].base, stat[id_idx].cur);
          ctl.ord = stat[id_idx].ord;
        end
      end
      S_ADD_DEQ: begin
        if (stat[idx_r].waiting) begin
          ctl.cmd = CC_DEQ;  ctl.idx = idx_r;
          ctl.lv  = queue_lv(stat[idx_r].base, stat[idx_r].cur);
          ctl.ord = stat[idx_r].ord;
        end
      end
      S_ENQ: begin
        ctl.cmd = enq_rq_r ? CC_REQUEUE : CC_ENQ;
        ctl.idx = idx_r;  ctl.base = slv;  ctl.cur = dlv;
        ctl.cnt = OrdW'(cnt_r);
      end
      S_PRE_ENQ: begin
        ctl.cmd = CC_ENQ;  ctl.idx = idx_r;
        ctl.base = stat[idx_r].base;  ctl.cur = run_lv_r;
        ctl.cnt = OrdW'(cnt_r);
      end
      S_SEL_DO: begin
        ctl.cmd = CC_SELECT;  ctl.idx = idx_r;
        ctl.lv  = lv_r;  ctl.ord = '0;
      end
      S_AGE_SCAN: begin
        if (age_hit) begin
          list_we = 1'b1;  list_wr_idx = IdxW'(nlist_r);
        end
      end
      S_AGE_DO: begin
        if (j_r != nlist_r) begin
          ctl.cmd = CC_AGE;  ctl.idx = list_r[IdxW'(j_r)];
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) out_load = 1'b1;
      end
      default: ;
    endcase
  end

  // Hold control state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  run_id_r <= '0;  run_lv_r <= '0;  tick_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  run_id_r <= run_id_nxt;  run_lv_r <= run_lv_nxt;
      tick_r <= tick_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (state_r == S_IDLE && in_valid) req_r <= in_data;
    if (out_load) begin
      out_r.running_valid <= (run_id_r != '0);
      out_r.running_id    <= run_id_r;
      out_r.status        <= status_r;
      out_r.preempted     <= pre_r;
      out_r.aged          <= aged_r;
    end
    if (list_we) list_r[list_wr_idx] <= k_r;
    idx_r <= idx_nxt;  lv_r <= lv_nxt;  cnt_r <= cnt_nxt;
    k_r <= k_nxt;  status_r <= status_nxt;  pre_r <= pre_nxt;  aged_r <= aged_nxt;
    enq_rq_r <= enq_rq_nxt;
    in_age_r <= in_age_nxt;  nlist_r <= nlist_nxt;
    j_r <= j_nxt;  scan_lv_r <= scan_lv_nxt;  scan_pos_r <= scan_pos_nxt;
    scan_hit_r <= scan_hit_nxt;
  end

endmodule

// ===== bench/psa_checker.sv =====
// Checker for the priority scheduler with aging: watches both channels,
// predicts each result beat and compares it. Depends on psa_pkg.
`timescale 1ns / 100ps

module psa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  psa_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  psa_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 beats_seen
);
  import psa_pkg::*;

  logic           waiting  [MaxTasks];
  logic [LvW-1:0] base_lv  [MaxTasks];
  logic [LvW-1:0] cur_lv   [MaxTasks];
  int             pos      [MaxTasks];
  logic           ran      [MaxTasks];
  int             cur_run;
  logic [LvW-1:0] cur_run_lv;
  int             ticks;
  logic           did_preempt;

  out_beat_t sched_results[$];

  function automatic int lane_of(int i);
    return (base_lv[i] == 0) ? 0 : int'(cur_lv[i]);
  endfunction

  task automatic push_tail(int i);
    int n;
    n = 0;
    for (int k = 0; k < MaxTasks; k++)
      if (waiting[k] && lane_of(k) == lane_of(i)) n++;
    pos[i] = n;
    waiting[i] = 1'b1;
  endtask

  task automatic pull_out(int i);
    waiting[i] = 1'b0;
    for (int k = 0; k < MaxTasks; k++)
      if (waiting[k] && lane_of(k) == lane_of(i) && pos[k] > pos[i]) pos[k]--;
  endtask

  task automatic pick_head();
    for (int lv = Levels - 1; lv >= 0; lv--)
      for (int k = 0; k < MaxTasks; k++)
        if (waiting[k] && lane_of(k) == lv && pos[k] == 0) begin
          cur_run = k + 1;
          cur_run_lv = cur_lv[k];
          ran[k] = 1'b1;
          pull_out(k);
          return;
        end
  endtask

  task automatic admit(int i);
    push_tail(i);
    if (base_lv[i] == 0) begin
      if (cur_run == 0) pick_head();
    end else if (cur_run == 0) begin
      pick_head();
    end else if (cur_lv[i] > cur_run_lv) begin
      cur_lv[cur_run-1] = cur_run_lv;
      push_tail(cur_run - 1);
      pick_head();
      did_preempt = 1'b1;
    end
  endtask

  task automatic age_all();
    int order[$];
    order = {};
    for (int lv = 1; lv < Levels; lv++)
      for (int p = 0; p < MaxTasks; p++)
        for (int k = 0; k < MaxTasks; k++)
          if (waiting[k] && lane_of(k) == lv && pos[k] == p) order = {order, k};
    foreach (order[j]) begin
      int k;
      k = order[j];
      waiting[k] = 1'b0;
      if (ran[k]) begin
        if (cur_lv[k] > base_lv[k]) cur_lv[k]--;
        else ran[k] = 1'b0;
      end else if (cur_lv[k] < Levels - 1) begin
        cur_lv[k]++;
      end
    end
    foreach (order[j]) admit(order[j]);
  endtask

  // Advance the model by one accepted beat and queue its result.
  task automatic predict_beat(in_beat_t b);
    out_beat_t r;
    int id, i;
    logic ok;
    id = b.task_id;
    ok = (id >= 1 && id <= MaxTasks);
    i = ok ? id - 1 : 0;
    r = '0;
    did_preempt = 1'b0;
    case (op_t'(b.op))
      OP_ADD: begin
        if (!ok || !b.is_ready || cur_run == id) begin
          r.status = ST_REJECT;
        end else begin
          if (waiting[i]) pull_out(i);
          base_lv[i] = b.static_level;
          cur_lv[i] = b.dynamic_level;
          admit(i);
        end
      end
      OP_REMOVE: begin
        if (!ok || !waiting[i] || cur_lv[i] != b.dynamic_level) r.status = ST_NOTFOUND;
        else pull_out(i);
      end
      OP_FINISH: begin
        cur_run = 0;
        cur_run_lv = '0;
        pick_head();
      end
      default: begin
        ticks++;
        if (ticks >= AgingPeriod) begin
          ticks = 0;
          r.aged = 1'b1;
          age_all();
        end
      end
    endcase
    r.running_valid = (cur_run != 0);
    r.running_id = cur_run[IdW-1:0];
    r.preempted = did_preempt;
    sched_results = {sched_results, r};
  endtask

  assign pending = sched_results.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MaxTasks; k++) begin
        waiting[k] = 1'b0; base_lv[k] = '0; cur_lv[k] = '0; pos[k] = 0; ran[k] = 1'b0;
      end
      cur_run = 0;
      cur_run_lv = '0;
      ticks = 0;
      fail_count = 0;
      beats_seen = 0;
      sched_results = {};
    end else begin
      // Compare the result beat with the oldest prediction.
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (sched_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          out_beat_t e;
          e = sched_results.pop_front();
          if (e.running_valid !== out_data.running_valid ||
              e.running_id !== out_data.running_id || e.status !== out_data.status ||
              e.preempted !== out_data.preempted || e.aged !== out_data.aged) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch beat %0d: expected %p actual %p", beats_seen, e, out_data);
          end
        end
      end
      if (in_valid && !in_stall) predict_beat(in_data);
    end
  end
endmodule

// ===== bench/tb_priority_scheduler_with_aging_top.sv =====
// Testbench top for the priority scheduler with aging: clock, reset, task
// stimulus and verdict. Depends on psa_pkg, psa_checker and the block.
`timescale 1ns / 100ps

module tb_priority_scheduler_with_aging_top;
  import psa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  int fail_count, pending, beats_seen;
  int sent = 0;
  logic hold_off = 1'b0;

  always #2 clk = ~clk;

  priority_scheduler_with_aging_top uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  psa_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending),
    .beats_seen(beats_seen)
  );

  // Build one random task beat; mostly legal ids and ready adds.
  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int r;
    r = $urandom_range(0, 99);
    b.op = (r < 45) ? OP_ADD : (r < 60) ? OP_REMOVE : (r < 75) ? OP_FINISH : OP_TICK;
    b.task_id = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    b.static_level = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom);
    b.dynamic_level = 4'($urandom);
    b.is_ready = ($urandom_range(0, 9) != 0);
    return b;
  endfunction

  // Offer one beat and hold it until accepted; drop valid only across a gap.
  task automatic send_beat(in_beat_t b, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic in_beat_t mk(op_t op, int id, int sl, int dl, bit rdy);
    in_beat_t b;
    b.op = op; b.task_id = 5'(id); b.static_level = 4'(sl);
    b.dynamic_level = 4'(dl); b.is_ready = rdy;
    return b;
  endfunction

  // Receiver: random stall per beat, one long hold-off on request.
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
        hold_off <= 1'b0;
      end else if (out_valid && !out_stall && $urandom_range(0, 1)) begin
        wait_n = $urandom_range(0, 17);
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: idle finish, rejects, range saturation, static-0, preempt, aging.
    send_beat(mk(OP_FINISH, 0, 0, 0, 1), 0);
    send_beat(mk(OP_ADD, 0, 5, 5, 1), 0);
    send_beat(mk(OP_ADD, 31, 5, 5, 1), 0);
    send_beat(mk(OP_ADD, 3, 5, 5, 0), 0);
    send_beat(mk(OP_REMOVE, 0, 0, 0, 1), 0);
    send_beat(mk(OP_REMOVE, 17, 0, 0, 1), 0);
    send_beat(mk(OP_ADD, 1, 0, 15, 1), 0);
    send_beat(mk(OP_ADD, 2, 0, 3, 1), 0);
    send_beat(mk(OP_ADD, 1, 4, 4, 1), 0);
    send_beat(mk(OP_ADD, 3, 2, 2, 1), 0);
    send_beat(mk(OP_ADD, 4, 15, 15, 1), 0);
    send_beat(mk(OP_ADD, 16, 1, 1, 1), 0);
    send_beat(mk(OP_ADD, 3, 6, 7, 1), 0);
    send_beat(mk(OP_REMOVE, 3, 0, 6, 1), 0);
    send_beat(mk(OP_REMOVE, 3, 0, 7, 1), 0);
    send_beat(mk(OP_ADD, 5, 15, 0, 1), 0);
    repeat (6) send_beat(mk(OP_TICK, 0, 0, 0, 0), 0);
    send_beat(mk(OP_FINISH, 0, 0, 0, 0), 0);
    send_beat(mk(OP_FINISH, 0, 0, 0, 0), 0);
    send_beat(mk(OP_FINISH, 0, 0, 0, 0), 0);
    // Random part, with one long receiver hold-off early on.
    for (int n = 0; n < 1500; n++) begin
      if (n == 200) hold_off <= 1'b1;
      send_beat(rand_beat(), ($urandom_range(0, 3) != 0) && (n < 200 || n > 260));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d task beats, %0d result beats checked", sent, beats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_priority_scheduler_with_aging_top passed");
    end else begin
      $display("tb_priority_scheduler_with_aging_top failed");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("tb_priority_scheduler_with_aging_top failed");
    $finish;
  end
endmodule
